### design/tbsm_pkg.sv
// shared types and constants for the three-button settings menu
package tbsm_pkg;

	localparam int unsigned ENTER_HOLD_MS = 5000;
	localparam int unsigned SAVE_HOLD_MS  = 3000;
	localparam int unsigned HOLD_TIME_RST = 1000;
	localparam int unsigned PCT_FULL      = 100;
	localparam int unsigned PCT_NONE      = 127;
	localparam int unsigned DIV_STEPS     = 23;

	typedef enum logic [1:0] {
		MODE_MAIN     = 2'd0,
		MODE_SETTINGS = 2'd1,
		MODE_CONFIRM  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		FIELD_LOW   = 2'd0,
		FIELD_HIGH  = 2'd1,
		FIELD_ALERT = 2'd2
	} field_t;

	// controller to datapath
	typedef struct packed {
		logic step;     // register button item and run menu logic
		logic div_go;   // start divide of the captured progress product
		logic finish;   // take quotient and complete the item
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_sts_t;

endpackage

### design/tbsm_div.sv
// serial restoring divider, one quotient bit per cycle
module tbsm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [22:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [22:0] quotient
);
	import tbsm_pkg::*;

	logic [22:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[22]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	// remainder stays below the divisor, so 16 bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
			quo_q <= {quo_q[21:0], fits};
		end
	end

	assign quotient = quo_q;
endmodule

### design/tbsm_datapath.sv
// menu state registers, button edge logic and progress arithmetic
module tbsm_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  tbsm_pkg::dp_cmd_t cmd,
	output tbsm_pkg::dp_sts_t sts,
	input  logic [15:0]      hold_time,
	input  logic             ok_pressed,
	input  logic             down_pressed,
	input  logic             up_pressed,
	output logic [1:0]       ui_mode,
	output logic [1:0]       field_selected,
	output logic             confirm_no,
	output logic signed [7:0] limit_low,
	output logic signed [7:0] limit_high,
	output logic             alert_on,
	output logic [6:0]       progress_percent,
	output logic             progress_changed,
	output logic             hold_complete,
	output logic             save_request
);
	import tbsm_pkg::*;

	logic [1:0]  mode_q;
	logic [12:0] solo_ms_q;
	logic        solo_done_q, ignore_ok_q, prog_act_q;
	logic [15:0] elapsed_q;
	logic [6:0]  last_pct_q;
	logic [1:0]  field_q;
	logic        choice_q;
	logic [2:0]  prev_q;
	logic [11:0] set_ms_q;
	logic        armed_q;
	logic signed [7:0] low_q, high_q;
	logic        alert_q;
	logic [22:0] prod_q;
	logic        div_pend_q;

	logic [1:0]  mode_n;
	logic [12:0] solo_ms_n;
	logic        solo_done_n, ignore_ok_n, prog_act_n;
	logic [15:0] elapsed_n;
	logic [6:0]  last_pct_n;
	logic [1:0]  field_n;
	logic        choice_n;
	logic [2:0]  prev_n;
	logic [11:0] set_ms_n;
	logic        armed_n;
	logic signed [7:0] low_n, high_n;
	logic        alert_n;
	logic        save_n, need_div_n;
	logic [22:0] prod_n;
	logic        ok, dn, up, ok_e, dn_e, up_e;
	logic [11:0] set_inc;
	logic signed [8:0] v;
	logic        div_done;
	logic [22:0] quo;
	logic [6:0]  pct;

	assign ok = ok_pressed;
	assign dn = down_pressed;
	assign up = up_pressed;
	assign ok_e = ok && !prev_q[0];
	assign dn_e = dn && !prev_q[1];
	assign up_e = up && !prev_q[2];

	always_comb begin
		mode_n = mode_q; solo_ms_n = solo_ms_q; solo_done_n = solo_done_q;
		ignore_ok_n = ignore_ok_q; prog_act_n = prog_act_q; elapsed_n = elapsed_q;
		last_pct_n = last_pct_q; field_n = field_q; choice_n = choice_q;
		prev_n = prev_q; set_ms_n = set_ms_q; armed_n = armed_q;
		low_n = low_q; high_n = high_q; alert_n = alert_q;
		save_n = 1'b0; need_div_n = 1'b0; prod_n = '0; v = '0;
		set_inc = (set_ms_q == 12'hFFF) ? set_ms_q : set_ms_q + 12'd1;
		unique case (mode_q)
			MODE_CONFIRM: begin
				if (dn_e) choice_n = 1'b1;
				if (up_e) choice_n = 1'b0;
				if (ok_e && !ignore_ok_q) begin
					if (!choice_n) begin
						save_n = 1'b1;
						mode_n = MODE_MAIN;
					end else begin
						mode_n = MODE_SETTINGS;
					end
				end
				if (!ok) ignore_ok_n = 1'b0;
				prev_n = {up, dn, ok};
			end
			MODE_SETTINGS: begin
				if (dn_e) begin
					if (field_q == FIELD_LOW) begin
						v = 9'(low_n) + 9'sd1;
						low_n = (v < 9'(high_n) - 9'sd1) ? 8'(v) : high_n - 8'sd1;
					end else if (field_q == FIELD_HIGH) begin
						v = 9'(high_n) + 9'sd1;
						high_n = (v < 9'sd100) ? 8'(v) : 8'sd100;
					end else if (field_q == FIELD_ALERT) begin
						alert_n = !alert_n;
					end
				end
				if (up_e) begin
					if (field_q == FIELD_LOW) begin
						v = 9'(low_n) - 9'sd1;
						low_n = (v > -9'sd100) ? 8'(v) : -8'sd100;
					end else if (field_q == FIELD_HIGH) begin
						v = 9'(high_n) - 9'sd1;
						high_n = (v > 9'(low_n) + 9'sd1) ? 8'(v) : low_n + 8'sd1;
					end else if (field_q == FIELD_ALERT) begin
						alert_n = !alert_n;
					end
				end
				if (ok) begin
					if (ok_e) begin
						armed_n = 1'b1;
						set_ms_n = '0;
					end else if (armed_q) begin
						set_ms_n = set_inc;
						if (set_inc >= 12'(SAVE_HOLD_MS)) begin
							mode_n = MODE_CONFIRM;
							choice_n = 1'b0;
							armed_n = 1'b0;
							set_ms_n = '0;
						end
					end
				end else begin
					if (prev_q[0] && armed_q && (13'(set_ms_q) + 13'd1 < 13'(SAVE_HOLD_MS)))
						field_n = (field_q == FIELD_ALERT) ? FIELD_LOW :
							(field_q == FIELD_LOW) ? FIELD_HIGH : FIELD_ALERT;
					armed_n = 1'b0;
					set_ms_n = '0;
				end
				if (!ok) ignore_ok_n = 1'b0;
				prev_n = {up, dn, ok};
			end
			default: begin
				if (ok && !dn && !up) begin
					if (!solo_done_q) begin
						if (solo_ms_q >= 13'(ENTER_HOLD_MS)) begin
							solo_done_n = 1'b1;
							solo_ms_n = '0;
							mode_n = MODE_SETTINGS;
							ignore_ok_n = 1'b1;
							prev_n[0] = 1'b1;
						end else begin
							solo_ms_n = solo_ms_q + 13'd1;
						end
					end
				end else begin
					solo_ms_n = '0;
					solo_done_n = 1'b0;
				end
				if (mode_n == mode_q) begin
					if ((ok && dn) || (ok && up) || (dn && up)) begin
						// restart gives elapsed zero for this item
						if (!prog_act_q) begin
							prod_n = '0;
							elapsed_n = 16'd1;
							last_pct_n = 7'(PCT_NONE);
						end else begin
							prod_n = 23'(elapsed_q) * 23'd100;
							elapsed_n = (elapsed_q == 16'hFFFF) ? elapsed_q
								: elapsed_q + 16'd1;
						end
						prog_act_n = 1'b1;
						need_div_n = 1'b1;
					end else begin
						prog_act_n = 1'b0;
						last_pct_n = 7'(PCT_NONE);
					end
				end
			end
		endcase
	end

	tbsm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_go),
		.dividend(prod_q),
		.divisor (hold_time),
		.done    (div_done),
		.quotient(quo)
	);

	assign pct = (hold_time == '0 || quo >= 23'(PCT_FULL)) ? 7'(PCT_FULL) : quo[6:0];

	assign sts.need_div = div_pend_q;
	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MAIN; solo_ms_q <= '0; solo_done_q <= 1'b0;
			ignore_ok_q <= 1'b0; prog_act_q <= 1'b0; elapsed_q <= '0;
			last_pct_q <= 7'(PCT_NONE); field_q <= FIELD_LOW; choice_q <= 1'b0;
			prev_q <= '0; set_ms_q <= '0; armed_q <= 1'b0;
			low_q <= '0; high_q <= 8'sd100; alert_q <= 1'b0;
			div_pend_q <= 1'b0;
			ui_mode <= '0; field_selected <= '0; confirm_no <= 1'b0;
			limit_low <= '0; limit_high <= 8'sd100; alert_on <= 1'b0;
			progress_percent <= '0; progress_changed <= 1'b0;
			hold_complete <= 1'b0; save_request <= 1'b0;
		end else begin
			if (cmd.step) begin
				mode_q <= mode_n; solo_ms_q <= solo_ms_n; solo_done_q <= solo_done_n;
				ignore_ok_q <= ignore_ok_n; prog_act_q <= prog_act_n;
				elapsed_q <= elapsed_n; last_pct_q <= last_pct_n; field_q <= field_n;
				choice_q <= choice_n; prev_q <= prev_n; set_ms_q <= set_ms_n;
				armed_q <= armed_n; low_q <= low_n; high_q <= high_n;
				alert_q <= alert_n; div_pend_q <= need_div_n;
				ui_mode <= mode_n; field_selected <= field_n; confirm_no <= choice_n;
				limit_low <= low_n; limit_high <= high_n; alert_on <= alert_n;
				progress_percent <= '0; progress_changed <= 1'b0;
				hold_complete <= 1'b0; save_request <= save_n;
			end
			if (cmd.finish) begin
				div_pend_q <= 1'b0;
				progress_percent <= pct;
				progress_changed <= (pct != last_pct_q);
				last_pct_q <= pct;
				if (pct >= 7'(PCT_FULL)) begin
					hold_complete <= 1'b1;
					prog_act_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) prod_q <= prod_n;
	end
endmodule

### design/tbsm_ctrl.sv
// item sequencing: accept, optional divide, hold result for the output side
module tbsm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output tbsm_pkg::dp_cmd_t cmd,
	input  tbsm_pkg::dp_sts_t sts
);
	import tbsm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE, ST_EVAL, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = (state_q == ST_OUT);
	assign cmd.step   = (state_q == ST_IDLE) && in_valid;
	assign cmd.div_go = (state_q == ST_EVAL) && sts.need_div;
	assign cmd.finish = (state_q == ST_DIV) && sts.div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_EVAL;
				ST_EVAL: state_q <= sts.need_div ? ST_DIV : ST_OUT;
				ST_DIV:  if (sts.div_done) state_q <= ST_OUT;
				ST_OUT:  if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### design/three_button_settings_menu_core.sv
// top level of the three-button settings menu
// One item per millisecond tick of button levels gives one result item. An item
// without a two-button hold passes through the idle, eval and output states; one
// with a two-button hold also waits in the divide state for the serial divider that
// forms the progress percentage one quotient bit per cycle. One item is in flight
// at a time; the next is accepted the cycle after its result is taken. hold_time
// must be written only while idle; the block itself does not enforce this.
module three_button_settings_menu_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             ok_pressed,
	input  logic             down_pressed,
	input  logic             up_pressed,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       ui_mode,
	output logic [1:0]       field_selected,
	output logic             confirm_no,
	output logic signed [7:0] limit_low,
	output logic signed [7:0] limit_high,
	output logic             alert_on,
	output logic [6:0]       progress_percent,
	output logic             progress_changed,
	output logic             hold_complete,
	output logic             save_request
);
	import tbsm_pkg::*;

	logic [15:0] hold_time_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_time_q <= 16'(HOLD_TIME_RST);
		else if (cfg_we) hold_time_q <= cfg_wdata;
	end

	tbsm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	tbsm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .hold_time(hold_time_q),
		.ok_pressed(ok_pressed), .down_pressed(down_pressed), .up_pressed(up_pressed),
		.ui_mode(ui_mode), .field_selected(field_selected), .confirm_no(confirm_no),
		.limit_low(limit_low), .limit_high(limit_high), .alert_on(alert_on),
		.progress_percent(progress_percent), .progress_changed(progress_changed),
		.hold_complete(hold_complete), .save_request(save_request)
	);
endmodule
